@@ hdl/induction_heater_burst_pwm_assert.svh @@
// Assertion macros for the induction heater burst PWM block.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef INDUCTION_HEATER_BURST_PWM_ASSERT_SVH
`define INDUCTION_HEATER_BURST_PWM_ASSERT_SVH

// Clocked check, switched off while reset is applied
`define IHBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that must also hold during reset
`define IHBP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hdl/ihbp_pkg.sv @@
// Shared types and constants of the induction heater burst PWM block.
// No dependencies; every design module imports this package.
package ihbp_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 24;

  // Field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned POWER_W    = 17;
  localparam int unsigned TIME_W     = 15;
  localparam int unsigned MULT_W     = 8;
  localparam int unsigned OSC_W      = 16;
  localparam int unsigned CMP_W      = 24;
  localparam int unsigned MINCC_W    = 18;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [CMP_W-1:0]   OFF_COMPARE     = 24'hFF_FFFF;
  localparam int unsigned        MIN_OFF_PERIODS = 3;
  localparam logic [POWER_W-1:0] FULL_POWER      = 17'h1_0000;

  // Command codes of an input word
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POWER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ON = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_ON  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS = 3'd4;

  // Register reset values
  localparam logic [TIME_W-1:0] FIRST_ON_RST = 15'd60;
  localparam logic [TIME_W-1:0] MAIN_ON_RST  = 15'd120;
  localparam logic [TIME_W-1:0] OFF_RST      = 15'd600;
  localparam logic [MULT_W-1:0] MULT_RST     = 8'd16;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [POWER_W-1:0] power;
    logic               overvoltage;
  } in_t;

  typedef struct packed {
    logic             gate;
    logic             faulted;
    logic [CMP_W-1:0] compare_now;
    logic             burst_window;
  } out_t;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_POWER,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [POWER_W-1:0] power;
    logic               overvoltage;
  } q_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] first_on;
    logic [TIME_W-1:0] main_on;
    logic [TIME_W-1:0] off;
    logic [MULT_W-1:0] mult;
    logic              fault_suppress;
  } cfg_t;

  typedef struct packed {
    logic [OSC_W-1:0]  osc_period;
    logic [TIME_W-1:0] first_delay;
  } tim_t;

  typedef struct packed {
    logic               start;
    logic [POWER_W-1:0] power;
  } sp_req_t;

  typedef enum logic [1:0] {
    SPK_OFF,
    SPK_FULL,
    SPK_VALUE
  } sp_kind_e;

  typedef struct packed {
    logic             done;
    sp_kind_e         kind;
    logic [CMP_W-1:0] value;
  } sp_res_t;

endpackage

@@ hdl/induction_heater_burst_pwm.sv @@
// Induction heater burst PWM drive. A tick, clear or unused command is stored in
// the queue, taken from it when the back end can go and answered in the registered
// result word. A set-power word holds the back end from its pop until the answer is
// applied (multiply, a bit-serial remainder of COUNT_WIDTH + 1 steps, compare forming,
// apply), and its result word follows the apply. Throughput: one tick per cycle while
// the result word is taken and no set-power word is in work. Reset is asynchronous.
module induction_heater_burst_pwm #(
  parameter int unsigned COUNT_WIDTH = ihbp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ihbp_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ihbp_pkg::out_t                      out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ihbp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ihbp_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ihbp_pkg::*;

  localparam int unsigned PW = COUNT_WIDTH + 1;
  localparam int unsigned XW = (PW > CMP_W) ? PW : CMP_W;

  cfg_t             cfg_q;
  tim_t             tim;
  logic [OSC_W-1:0] osc_sum;
  logic [MULT_W-1:0] mult_eff;
  logic [CMP_W-1:0] period_prod;
  logic [XW-1:0]    period_lim;
  logic [PW-1:0]    pwm_period;
  q_item_t          q_head;
  logic             q_valid, q_pop;
  sp_req_t          sp_req;
  sp_res_t          sp_res;

  // Register file; writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_on       <= FIRST_ON_RST;
      cfg_q.main_on        <= MAIN_ON_RST;
      cfg_q.off            <= OFF_RST;
      cfg_q.mult           <= MULT_RST;
      cfg_q.fault_suppress <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FIRST_ON: cfg_q.first_on       <= cfg_data_i[TIME_W-1:0];
        CFG_MAIN_ON:  cfg_q.main_on        <= cfg_data_i[TIME_W-1:0];
        CFG_OFF:      cfg_q.off            <= cfg_data_i[TIME_W-1:0];
        CFG_MULT:     cfg_q.mult           <= cfg_data_i[MULT_W-1:0];
        CFG_SUPPRESS: cfg_q.fault_suppress <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Derive oscillator period, first-pulse delay and clamped PWM period
  assign osc_sum         = OSC_W'(cfg_q.main_on) + OSC_W'(cfg_q.off);
  assign tim.osc_period  = (osc_sum == '0) ? OSC_W'(1) : osc_sum;
  assign tim.first_delay = (cfg_q.main_on >= cfg_q.first_on) ? cfg_q.main_on - cfg_q.first_on
                                                             : '0;
  assign mult_eff        = (cfg_q.mult == '0) ? MULT_W'(1) : cfg_q.mult;
  assign period_prod     = CMP_W'(tim.osc_period) * CMP_W'(mult_eff);
  assign period_lim      = XW'(1) << COUNT_WIDTH;
  assign pwm_period      = (XW'(period_prod) > period_lim) ? PW'(period_lim)
                                                           : PW'(period_prod);

  ihbp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_pop_i    (q_pop),
    .q_valid_o  (q_valid),
    .q_head_o   (q_head)
  );

  ihbp_setpow #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_setpow (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tim_i        (tim),
    .pwm_period_i (pwm_period),
    .req_i        (sp_req),
    .res_o        (sp_res)
  );

  ihbp_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .tim_i        (tim),
    .pwm_period_i (pwm_period),
    .q_valid_i    (q_valid),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .sp_req_o     (sp_req),
    .sp_res_i     (sp_res),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

@@ hdl/ihbp_front.sv @@
// Front end: accepts input words, classifies them and queues them.
// Depends on ihbp_pkg.
module ihbp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ihbp_pkg::in_t     in_data_i,
  input  logic              q_pop_i,
  output logic              q_valid_o,
  output ihbp_pkg::q_item_t q_head_o
);
  import ihbp_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  q_item_t          slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  q_item_t          item;
  logic             push, pop;

  // Classify the command and clamp the power request to full
  always_comb begin
    item.overvoltage = in_data_i.overvoltage;
    item.power = (in_data_i.power > FULL_POWER) ? FULL_POWER : in_data_i.power;
    unique case (in_data_i.cmd)
      CMD_TICK:  item.op = OP_TICK;
      CMD_POWER: item.op = OP_POWER;
      CMD_CLEAR: item.op = OP_CLEAR;
      default:   item.op = OP_NOP;
    endcase
  end

  assign in_stall_o = (count_q == CntW'(QUEUE_DEPTH));
  assign q_valid_o  = (count_q != '0);
  assign q_head_o   = slot_q[rd_ptr_q];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the classified word
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item;
    end
  end

endmodule

@@ hdl/ihbp_setpow.sv @@
// Set-power unit: scales the Q16 request by the PWM period, rounds down to whole
// oscillator periods with a bit-serial remainder and forms the compare value.
// Depends on ihbp_pkg.
module ihbp_setpow #(
  parameter int unsigned COUNT_WIDTH = ihbp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ihbp_pkg::tim_t       tim_i,
  input  logic [COUNT_WIDTH:0] pwm_period_i,
  input  ihbp_pkg::sp_req_t    req_i,
  output ihbp_pkg::sp_res_t    res_o
);
  import ihbp_pkg::*;

  localparam int unsigned PW   = COUNT_WIDTH + 1;
  localparam int unsigned CntW = $clog2(PW + 1);
  localparam int unsigned CCW  = (PW + 1 > MINCC_W) ? PW + 1 : MINCC_W;
  localparam int unsigned SW   = (CCW > CMP_W) ? CCW : CMP_W;

  typedef enum logic [2:0] {
    SP_IDLE,
    SP_MUL,
    SP_DIV,
    SP_ON,
    SP_FIN
  } state_e;

  state_e               state_q, state_d;
  logic [POWER_W-1:0]   power_q, power_d;
  logic [PW-1:0]        ideal_q, ideal_d;
  logic [PW-1:0]        shf_q, shf_d;
  logic [OSC_W-1:0]     rem_q, rem_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [PW-1:0]        on_q, on_d;
  sp_res_t              res_q, res_d;

  logic [PW+15:0]       prod;
  logic [PW-1:0]        mul_ideal;
  logic [OSC_W:0]       shl;
  logic                 shl_ge;
  logic [MINCC_W-1:0]   min_cc;
  logic [CCW-1:0]       cc_raw, cc_max;
  logic [SW-1:0]        cc_sw;
  logic [CMP_W-1:0]     cc_sat;

  // Scale: full power gives the period itself
  assign prod      = (PW + 16)'(power_q[15:0]) * (PW + 16)'(pwm_period_i);
  assign mul_ideal = power_q[16] ? pwm_period_i : prod[PW+15:16];

  // One remainder bit a cycle
  assign shl    = {rem_q, shf_q[PW-1]};
  assign shl_ge = (shl >= {1'b0, tim_i.osc_period});

  // Compare value with the minimum off time enforced
  assign min_cc = MINCC_W'(tim_i.osc_period) * MINCC_W'(MIN_OFF_PERIODS)
                + MINCC_W'(tim_i.first_delay);
  assign cc_raw = CCW'(pwm_period_i) - CCW'(on_q) + CCW'(tim_i.first_delay);
  assign cc_max = (cc_raw < CCW'(min_cc)) ? CCW'(min_cc) : cc_raw;
  assign cc_sw  = SW'(cc_max);
  assign cc_sat = (cc_sw > SW'(OFF_COMPARE)) ? OFF_COMPARE : cc_sw[CMP_W-1:0];

  always_comb begin
    state_d    = state_q;
    power_d    = power_q;
    ideal_d    = ideal_q;
    shf_d      = shf_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    on_d       = on_q;
    res_d      = res_q;
    res_d.done = 1'b0;
    unique case (state_q)
      SP_IDLE: begin
        if (req_i.start) begin
          power_d = req_i.power;
          state_d = SP_MUL;
        end
      end
      SP_MUL: begin
        ideal_d = mul_ideal;
        shf_d   = mul_ideal;
        rem_d   = '0;
        cnt_d   = CntW'(PW);
        state_d = SP_DIV;
      end
      SP_DIV: begin
        rem_d = shl_ge ? OSC_W'(shl - {1'b0, tim_i.osc_period}) : shl[OSC_W-1:0];
        shf_d = shf_q << 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          state_d = SP_ON;
        end
      end
      SP_ON: begin
        on_d    = ideal_q - PW'(rem_q);
        state_d = SP_FIN;
      end
      SP_FIN: begin
        res_d.done = 1'b1;
        priority if (on_q == '0) begin
          res_d.kind  = SPK_OFF;
          res_d.value = OFF_COMPARE;
        end else if (on_q == pwm_period_i) begin
          res_d.kind  = SPK_FULL;
          res_d.value = CMP_W'(min_cc);
        end else begin
          res_d.kind  = SPK_VALUE;
          res_d.value = cc_sat;
        end
        state_d = SP_IDLE;
      end
      default: state_d = SP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SP_IDLE;
      power_q <= '0;
      ideal_q <= '0;
      shf_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      on_q    <= '0;
      res_q   <= '{done: 1'b0, kind: SPK_OFF, value: OFF_COMPARE};
    end else begin
      state_q <= state_d;
      power_q <= power_d;
      ideal_q <= ideal_d;
      shf_q   <= shf_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      on_q    <= on_d;
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ hdl/ihbp_back.sv @@
// Back end: oscillator and PWM counters, compare registers, fault latch and
// the result word register. Depends on ihbp_pkg and the assertion header.
`include "induction_heater_burst_pwm_assert.svh"
module ihbp_back #(
  parameter int unsigned COUNT_WIDTH = ihbp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ihbp_pkg::cfg_t       cfg_i,
  input  ihbp_pkg::tim_t       tim_i,
  input  logic [COUNT_WIDTH:0] pwm_period_i,
  input  logic                 q_valid_i,
  input  ihbp_pkg::q_item_t    q_head_i,
  output logic                 q_pop_o,
  output ihbp_pkg::sp_req_t    sp_req_o,
  input  ihbp_pkg::sp_res_t    sp_res_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ihbp_pkg::out_t       out_data_o
);
  import ihbp_pkg::*;

  localparam int unsigned PW = COUNT_WIDTH + 1;
  localparam int unsigned XW = (COUNT_WIDTH > CMP_W) ? COUNT_WIDTH : CMP_W;
  localparam int unsigned FW = (PW > CMP_W) ? PW : CMP_W;

  typedef enum logic {
    BK_RUN,
    BK_WAIT
  } state_e;

  state_e                 state_q, state_d;
  logic                   out_valid_q, out_valid_d;
  logic [OSC_W-1:0]       osc_count_q, osc_count_d;
  logic [COUNT_WIDTH-1:0] pwm_count_q, pwm_count_d;
  logic [CMP_W-1:0]       cmp_act_q, cmp_act_d;
  logic [CMP_W-1:0]       cmp_buf_q, cmp_buf_d;
  logic                   fault_q, fault_d;

  logic                   can_go;
  logic [OSC_W:0]         osc_inc;
  logic [PW-1:0]          pwm_inc;
  logic                   window;

  assign can_go  = (state_q == BK_RUN) && q_valid_i && (!out_valid_q || !out_stall_i);
  assign osc_inc = {1'b0, osc_count_q} + 1'b1;
  assign pwm_inc = {1'b0, pwm_count_q} + 1'b1;

  always_comb begin
    state_d        = state_q;
    out_valid_d    = out_valid_q;
    osc_count_d    = osc_count_q;
    pwm_count_d    = pwm_count_q;
    cmp_act_d      = cmp_act_q;
    cmp_buf_d      = cmp_buf_q;
    fault_d        = fault_q;
    q_pop_o        = 1'b0;
    sp_req_o.start = 1'b0;
    sp_req_o.power = q_head_i.power;
    // Drop the result word once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      BK_RUN: begin
        if (can_go) begin
          q_pop_o = 1'b1;
          unique case (q_head_i.op)
            OP_TICK: begin
              if (q_head_i.overvoltage && !cfg_i.fault_suppress) begin
                fault_d = 1'b1;
              end
              osc_count_d = (osc_inc >= {1'b0, tim_i.osc_period}) ? '0
                                                                   : osc_inc[OSC_W-1:0];
              if (pwm_inc >= pwm_period_i) begin
                pwm_count_d = '0;
                cmp_act_d   = cmp_buf_q;
              end else begin
                pwm_count_d = pwm_inc[COUNT_WIDTH-1:0];
              end
              out_valid_d = 1'b1;
            end
            OP_POWER: begin
              sp_req_o.start = 1'b1;
              state_d        = BK_WAIT;
            end
            OP_CLEAR: begin
              fault_d     = 1'b0;
              osc_count_d = '0;
              pwm_count_d = '0;
              cmp_act_d   = OFF_COMPARE;
              cmp_buf_d   = OFF_COMPARE;
              out_valid_d = 1'b1;
            end
            OP_NOP: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      BK_WAIT: begin
        // Apply the set-power answer
        if (sp_res_i.done) begin
          unique case (sp_res_i.kind)
            SPK_FULL: begin
              if (FW'(cmp_act_q) < FW'(pwm_period_i)) begin
                cmp_buf_d = '0;
              end else begin
                cmp_act_d = sp_res_i.value;
                cmp_buf_d = sp_res_i.value;
              end
            end
            default: begin
              cmp_act_d = sp_res_i.value;
              cmp_buf_d = sp_res_i.value;
            end
          endcase
          out_valid_d = 1'b1;
          state_d     = BK_RUN;
        end
      end
      default: state_d = BK_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_RUN;
      out_valid_q <= 1'b0;
      osc_count_q <= '0;
      pwm_count_q <= '0;
      cmp_act_q   <= OFF_COMPARE;
      cmp_buf_q   <= OFF_COMPARE;
      fault_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      osc_count_q <= osc_count_d;
      pwm_count_q <= pwm_count_d;
      cmp_act_q   <= cmp_act_d;
      cmp_buf_q   <= cmp_buf_d;
      fault_q     <= fault_d;
    end
  end

  // Result fields follow the state, which holds while the word waits
  assign window                  = (XW'(pwm_count_q) >= XW'(cmp_act_q));
  assign out_valid_o             = out_valid_q;
  assign out_data_o.gate         = !fault_q && (osc_count_q < OSC_W'(cfg_i.main_on))
                                   && window;
  assign out_data_o.faulted      = fault_q;
  assign out_data_o.compare_now  = cmp_act_q;
  assign out_data_o.burst_window = window;

  `IHBP_ASSERT_RST(a_done_in_wait, sp_res_i.done |-> state_q == BK_WAIT, "set-power answer outside wait")
  `IHBP_ASSERT(a_start_frees_out, sp_req_o.start |=> state_q == BK_WAIT && !out_valid_q, "start with word pending")
  `IHBP_ASSERT(a_hold_stalled, out_valid_q && out_stall_i |=> $stable(pwm_count_q) && $stable(osc_count_q) && $stable(cmp_act_q), "state moved under a stalled word")

endmodule
